### hdl/bbc_pkg.sv
// Package with the constants, types and state codes of the Bollinger band calculator.
`default_nettype none
package bbc_pkg;
  localparam int WindowMaxDefault = 64;
  localparam int PriceBitsDefault = 24;
  localparam int BandBits = 28;
  localparam int WinRegBits = 7;
  localparam int MultBits = 12;
  localparam int AddrBits = 3;
  localparam logic [AddrBits-1:0] AddrWindow = 3'd0;
  localparam logic [AddrBits-1:0] AddrMult = 3'd4;
  localparam logic [WinRegBits-1:0] WindowReset = 7'd20;
  localparam logic [MultBits-1:0] MultReset = 12'd512;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_OLD, ST_SQ, ST_ACC, ST_NSQ, ST_SSQ, ST_VAR,
    ST_DIV, ST_SQRT, ST_MDIV, ST_OFS, ST_BAND, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### hdl/bbc_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
`default_nettype none
interface bbc_stream_if #(parameter int Width = 8) (input wire logic clk);
  logic valid;
  logic ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/bbc_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module bbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hdl/bollinger_band_calculator.sv
// Top level of the Bollinger band calculator: ring, running sums and a shared sequencer.
// The input is ready again the cycle after the result transaction, so a new sample is only
// taken once the last result has gone out; a stalled output holds the block in its output state.
// The bit-serial steps are old sample squared, n times the square sum, sum squared,
// variance division, square root, mean division and the multiplier product, plus five
// steps of one state each around them.
// Reset (rst, synchronous) clears history, loads window 20 and multiplier 2.0.
`default_nettype none
module bollinger_band_calculator
  import bbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  bbc_stream_if.sink               in_ch,
  bbc_stream_if.source             out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);
  localparam int WINDOW_MAX = WindowMaxDefault;
  localparam int PRICE_BITS = PriceBitsDefault;
  localparam int SlotBits = $clog2(WINDOW_MAX);
  localparam int SumBits = PRICE_BITS + SlotBits + 1;
  localparam int SqBits = 2 * PRICE_BITS + SlotBits + 1;
  // n*sumsq needs SqBits+7 bits; sum^2 fits below it as well.
  localparam int WideBits = SqBits + WinRegBits + 1;
  localparam int RootBits = WideBits / 2 + 1;
  localparam int CntBits = $clog2(WideBits + 1);
  localparam logic [WinRegBits:0] WinMax = (WinRegBits + 1)'(WINDOW_MAX);

  // The input payload is {series_start, price}; the output payload is
  // {samples_used, lower_band, upper_band, middle_band}.
  logic [PRICE_BITS-1:0] price;
  logic series_start;
  assign price = in_ch.data[PRICE_BITS-1:0];
  assign series_start = in_ch.data[PRICE_BITS];

  // Configuration registers.
  logic [WinRegBits-1:0] window_length;
  logic [MultBits-1:0]   band_multiplier;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      AddrWindow: prdata = 32'(window_length);
      AddrMult:   prdata = 32'(band_multiplier);
      default:    prdata = '0;
    endcase
  end

  // Window clamped to 1..WINDOW_MAX.
  logic [WinRegBits:0] win;
  always_comb begin
    if (window_length == '0) win = (WinRegBits + 1)'(1);
    else if ({1'b0, window_length} > WinMax) win = WinMax;
    else win = {1'b0, window_length};
  end

  // History state.
  logic [SlotBits-1:0]   write_slot;
  logic [WinRegBits:0]   fill_count;
  logic [SumBits-1:0]    running_sum;
  logic [SqBits-1:0]     running_square_sum;
  logic                  full;

  state_t state, state_next;

  // Datapath registers shared by the sequencer steps.
  logic [PRICE_BITS-1:0] pr;
  logic [PRICE_BITS-1:0] old;
  logic [WideBits-1:0]   acc;   // remainder / radicand
  logic [WideBits-1:0]   quo;   // quotient / product under construction
  logic [WideBits-1:0]   den;
  logic [RootBits-1:0]   root;
  logic [CntBits-1:0]    cnt;
  logic [WideBits-1:0]   sumsq_n;
  logic [PRICE_BITS-1:0] mean;
  logic [BandBits:0]     offset;

  // RAM.
  logic [SlotBits-1:0]   ram_addr;
  logic                  ram_we;
  logic [PRICE_BITS-1:0] ram_rdata;
  logic [SlotBits-1:0]   old_slot;
  assign old_slot = write_slot - SlotBits'(win);

  bbc_ram #(.Width(PRICE_BITS), .Depth(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pr),
    .rdata (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_READ;
      ST_READ: state_next = ST_OLD;
      ST_OLD:  state_next = ST_SQ;
      ST_SQ:   if (cnt == '0) state_next = ST_ACC;
      ST_ACC:  state_next = ST_NSQ;
      ST_NSQ:  if (cnt == '0) state_next = ST_SSQ;
      ST_SSQ:  if (cnt == '0) state_next = ST_VAR;
      ST_VAR:  state_next = ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_SQRT;
      ST_SQRT: if (cnt == '0) state_next = ST_MDIV;
      ST_MDIV: if (cnt == '0) state_next = ST_OFS;
      ST_OFS:  if (cnt == '0) state_next = ST_BAND;
      ST_BAND: state_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    out_ch.valid = (state == ST_OUT);
    ram_we = (state == ST_ACC);
    ram_addr = (state == ST_ACC) ? write_slot : old_slot;
  end

  // Shared trial subtraction: restoring division takes den from the shifted remainder, and
  // the digit-by-digit root subtracts the term below; the shift-add multiplies do not use it.
  logic [WideBits:0] trial;
  logic [WideBits-1:0] shifted;
  logic [WideBits-1:0] sq_bit;
  assign sq_bit = WideBits'(1) << {cnt, 1'b0};
  always_comb begin
    shifted = {acc[WideBits-2:0], quo[WideBits-1]};
    unique case (state)
      // The partial root sits two places above the current bit pair, plus that bit squared.
      ST_SQRT: trial = {1'b0, acc}
                       - {1'b0, (WideBits'(root) << ({cnt, 1'b0} + 7'd2)) | sq_bit};
      default: trial = {1'b0, shifted} - {1'b0, den};
    endcase
  end

  logic [BandBits+1:0] up_w;
  logic [BandBits+1:0] lo_w;
  assign up_w = (BandBits + 2)'(mean) + (BandBits + 2)'(offset);
  assign lo_w = (BandBits + 2)'(mean) - (BandBits + 2)'(offset);

  logic [PRICE_BITS-1:0] mid_o;
  logic [BandBits-1:0]   up_o;
  logic [BandBits-1:0]   lo_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      window_length <= WindowReset;
      band_multiplier <= MultReset;
      write_slot <= '0;
      fill_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
      full <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr && paddr == AddrWindow) begin
        window_length <= pwdata[WinRegBits-1:0];
        write_slot <= '0;
        fill_count <= '0;
        running_sum <= '0;
        running_square_sum <= '0;
      end
      if (cfg_wr && paddr == AddrMult) band_multiplier <= pwdata[MultBits-1:0];
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          pr <= price;
          if (series_start) begin
            write_slot <= '0;
            fill_count <= '0;
            running_sum <= '0;
            running_square_sum <= '0;
          end
        end
        ST_READ: full <= (fill_count >= win);
        ST_OLD: begin
          // Old sample squared via shift-add, PRICE_BITS steps.
          old <= full ? ram_rdata : '0;
          quo <= '0;
          den <= WideBits'(full ? ram_rdata : '0);
          acc <= WideBits'(full ? ram_rdata : '0);
          cnt <= CntBits'(PRICE_BITS - 1);
          if (!full) fill_count <= fill_count + (WinRegBits + 1)'(1);
        end
        ST_SQ: begin
          // acc holds the multiplier bits; quo accumulates the product.
          quo <= (quo << 1) + (acc[cnt] ? den : '0);
          cnt <= cnt - CntBits'(1);
        end
        ST_ACC: begin
          running_sum <= running_sum - SumBits'(old) + SumBits'(pr);
          running_square_sum <= running_square_sum - SqBits'(quo) + SqBits'(pr) * SqBits'(pr);
          write_slot <= write_slot + SlotBits'(1);
        end
        ST_NSQ: ; // the product n*sumsq is stepped below
        default: ;
      endcase
      // Multi-cycle steps that follow.
      if (state == ST_ACC) begin
        // n*sumsq: n is at most 8 bits, so shift-add over its bits.
        quo <= '0;
        cnt <= CntBits'(WinRegBits);
      end
      if (state == ST_NSQ) begin
        quo <= (quo << 1) + (fill_count[cnt[$clog2(WinRegBits+1)-1:0]]
               ? WideBits'(running_square_sum) : '0);
        cnt <= cnt - CntBits'(1);
        if (cnt == '0) begin
          sumsq_n <= (quo << 1) + (fill_count[0] ? WideBits'(running_square_sum) : '0);
          quo <= '0;
          acc <= WideBits'(running_sum);
          cnt <= CntBits'(SumBits - 1);
        end
      end
      if (state == ST_SSQ) begin
        quo <= (quo << 1) + (acc[cnt] ? WideBits'(running_sum) : '0);
        cnt <= cnt - CntBits'(1);
      end
      if (state == ST_VAR) begin
        // Numerator for the variance division goes into quo, bits shifted out at top.
        quo <= (sumsq_n > quo) ? sumsq_n - quo : '0;
        acc <= '0;
        den <= WideBits'(16'(fill_count) * 16'(fill_count));
        cnt <= CntBits'(WideBits - 1);
      end
      if (state == ST_DIV) begin
        if (!trial[WideBits]) acc <= trial[WideBits-1:0];
        else acc <= shifted;
        quo <= {quo[WideBits-2:0], ~trial[WideBits]};
        cnt <= cnt - CntBits'(1);
        if (cnt == '0) begin
          acc <= {quo[WideBits-2:0], ~trial[WideBits]};
          root <= '0;
          cnt <= CntBits'(RootBits - 1);
        end
      end
      if (state == ST_SQRT) begin
        // acc is the remaining radicand, root the partial root.
        if (!trial[WideBits]) begin
          acc <= trial[WideBits-1:0];
          root <= {root[RootBits-2:0], 1'b1};
        end else begin
          root <= {root[RootBits-2:0], 1'b0};
        end
        cnt <= cnt - CntBits'(1);
        if (cnt == '0) begin
          quo <= WideBits'(running_sum) << (WideBits - SumBits);
          acc <= '0;
          den <= WideBits'(fill_count);
          cnt <= CntBits'(SumBits - 1);
        end
      end
      if (state == ST_MDIV) begin
        if (!trial[WideBits]) acc <= trial[WideBits-1:0];
        else acc <= shifted;
        quo <= {quo[WideBits-2:0], ~trial[WideBits]};
        cnt <= cnt - CntBits'(1);
        if (cnt == '0) begin
          mean <= PRICE_BITS'({quo[WideBits-2:0], ~trial[WideBits]});
          quo <= '0;
          cnt <= CntBits'(MultBits - 1);
        end
      end
      if (state == ST_OFS) begin
        quo <= (quo << 1) + (band_multiplier[cnt[$clog2(MultBits)-1:0]]
               ? WideBits'(root) : '0);
        cnt <= cnt - CntBits'(1);
        if (cnt == '0) begin
          offset <= (|(((quo << 1) + (band_multiplier[0] ? WideBits'(root) : '0))
                    >> (BandBits + 9))) ? {1'b1, {BandBits{1'b0}}}
                    : (BandBits + 1)'(((quo << 1) + (band_multiplier[0]
                    ? WideBits'(root) : '0)) >> 8);
        end
      end
      if (state == ST_BAND) begin
        mid_o <= mean;
        up_o <= up_w[BandBits+1:BandBits] != 2'b00 ? {BandBits{1'b1}} : up_w[BandBits-1:0];
        if (offset >= (BandBits + 1)'(mean)) begin
          lo_o <= (offset - (BandBits + 1)'(mean) > (BandBits + 1)'(1 << (BandBits - 1)))
                  ? {1'b1, {(BandBits - 1){1'b0}}} : lo_w[BandBits-1:0];
        end else begin
          lo_o <= lo_w[BandBits-1:0];
        end
      end
    end
  end

  assign out_ch.data = {fill_count[WinRegBits-1:0], lo_o, up_o, mid_o};
endmodule
`default_nettype wire

### hdl/bbc_checker.sv
// Port-level checker for the Bollinger band calculator, bound to the top level.
`default_nettype none
module bbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [86:0] out_data
);
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");
  a_n: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[86:80] != 7'd0)
    else $error("zero samples used");
endmodule

bind bollinger_band_calculator bbc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

### sim/bollinger_band_calculator_checker.sv
// Checker that predicts the band results of every accepted sample and compares them.
`default_nettype none
module bollinger_band_calculator_checker
  import bbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [24:0]         in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [86:0]         out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0]  used;
    logic [27:0] lower;
    logic [27:0] upper;
    logic [23:0] middle;
  } band_t;

  band_t         band_queue[$];
  logic [23:0]   price_ring[64];
  logic [5:0]    slot;
  logic [6:0]    fill;
  logic [63:0]   sum_acc;
  logic [63:0]   sq_acc;
  logic [6:0]    win_len;
  logic [11:0]   mult;

  assign pending = band_queue.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic predict_bands(input logic [23:0] price, input logic start);
    logic [63:0] oldest, n, mean, var_v, sd, offset, upper, mag, a, b;
    band_t       res;
    if (start) begin
      slot = 0; fill = 0; sum_acc = 0; sq_acc = 0;
    end
    if (fill >= win_len) begin
      oldest = 64'(price_ring[6'(slot - win_len[5:0])]);
      if (win_len == 7'd64) oldest = 64'(price_ring[slot]);
      sum_acc = sum_acc - oldest;
      sq_acc = sq_acc - oldest * oldest;
    end else begin
      fill = fill + 7'd1;
    end
    price_ring[slot] = price;
    slot = slot + 6'd1;
    sum_acc = sum_acc + 64'(price);
    sq_acc = sq_acc + 64'(price) * 64'(price);
    n = 64'(fill);
    mean = sum_acc / n;
    a = n * sq_acc;
    b = sum_acc * sum_acc;
    var_v = (a > b) ? (a - b) / (n * n) : 0;
    sd = int_sqrt(var_v);
    offset = (64'(mult) * sd) >> 8;
    upper = mean + offset;
    if (upper > 64'h0FFF_FFFF) upper = 64'h0FFF_FFFF;
    res.middle = mean[23:0];
    res.upper = upper[27:0];
    if (offset >= mean) begin
      mag = offset - mean;
      if (mag > 64'h0800_0000) mag = 64'h0800_0000;
      res.lower = 28'(0 - mag);
    end else begin
      res.lower = 28'(mean - offset);
    end
    res.used = n[6:0];
    band_queue.push_back(res);
  endtask

  always @(posedge clk) begin
    band_t got, exp_b;
    if (rst) begin
      slot = 0; fill = 0; sum_acc = 0; sq_acc = 0;
      win_len = WindowReset;
      mult = MultReset;
      band_queue.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrWindow) begin
          win_len = (pwdata[6:0] == 0) ? 7'd1 : (pwdata[6:0] > 7'd64) ? 7'd64 : pwdata[6:0];
          slot = 0; fill = 0; sum_acc = 0; sq_acc = 0;
        end else if (paddr == AddrMult) begin
          mult = pwdata[11:0];
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (band_queue.size() == 0) begin
          $error("result with no expected band: %h", out_data);
          fail_count++;
        end else begin
          exp_b = band_queue.pop_front();
          if (got.middle !== exp_b.middle) begin
            $error("middle_band expected %0d actual %0d", exp_b.middle, got.middle);
            fail_count++;
          end
          if (got.upper !== exp_b.upper) begin
            $error("upper_band expected %0d actual %0d", exp_b.upper, got.upper);
            fail_count++;
          end
          if (got.lower !== exp_b.lower) begin
            $error("lower_band expected %0d actual %0d",
                   $signed(exp_b.lower), $signed(got.lower));
            fail_count++;
          end
          if (got.used !== exp_b.used) begin
            $error("samples_used expected %0d actual %0d", exp_b.used, got.used);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_bands(in_data[23:0], in_data[24]);
    end
  end
endmodule
`default_nettype wire

### sim/bollinger_band_calculator_tb.sv
// Top of the testbench: clock, reset, stimulus, register writes and the verdict.
`default_nettype none
module bollinger_band_calculator_tb;
  import bbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 200;

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_len;
  int                  cycles;
  logic [23:0]         base_price;

  bbc_stream_if #(.Width(25)) sample_ch (.clk(clk));
  bbc_stream_if #(.Width(87)) band_ch (.clk(clk));

  bollinger_band_calculator i_dut (
    .clk(clk), .rst(rst), .in_ch(sample_ch.sink), .out_ch(band_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bollinger_band_calculator_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(sample_ch.valid), .in_ready(sample_ch.ready), .in_data(sample_ch.data),
    .out_valid(band_ch.valid), .out_ready(band_ch.ready), .out_data(band_ch.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles and ends a run that has hung.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // The receiver stalls at random, and during a requested hold-off it refuses every
  // transaction for the whole stretch so that the block backs up into its input.
  initial begin
    band_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        band_ch.ready <= 1'b0;
        hold_len--;
      end else begin
        band_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One sample transaction. Valid is only lowered when a gap is actually taken, so that
  // back-to-back transactions never see valid dropped and raised in the same step.
  task automatic send_sample(input logic [23:0] price, input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data <= {start, price};
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Register writes are only made with the block idle: every result has arrived and the
  // latency has passed, so that nothing is still in flight when the history is cleared.
  task automatic write_reg(input logic [AddrBits-1:0] addr, input logic [31:0] value);
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random samples are mostly a drifting series around a base price, which keeps the
  // deviation realistic, with full-range, extreme and small values and fresh series.
  task automatic send_random;
    logic [23:0] price;
    logic        start;
    int          pick;
    pick = $urandom_range(99);
    start = ($urandom_range(99) < 3);
    if (pick < 55) begin
      base_price = base_price + 24'($urandom_range(2000)) - 24'd1000;
      price = base_price + 24'($urandom_range(511));
    end else if (pick < 75) begin
      price = 24'($urandom);
    end else if (pick < 90) begin
      price = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
    end else begin
      price = 24'($urandom_range(15));
    end
    send_sample(price, start);
  endtask

  initial begin
    int phase;
    int i;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sample_ch.valid = 1'b0; sample_ch.data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_len = 0;
    base_price = 24'h80_0000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: extremes, a growing window and a restart.
    send_sample(24'h0, 1'b0);
    send_sample(24'hFF_FFFF, 1'b0);
    send_sample(24'hFF_FFFF, 1'b0);
    send_sample(24'h0, 1'b1);
    for (i = 0; i < 6; i++) send_sample(i[0] ? 24'hFF_FFFF : 24'h0, 1'b0);
    // A window of zero is taken as one; the largest multiplier is written as well.
    write_reg(AddrWindow, 32'd0);
    write_reg(AddrMult, 32'd4095);
    send_sample(24'h12_3456, 1'b0);
    send_sample(24'hFF_FFFF, 1'b0);
    // An over-long window saturates at the maximum.
    write_reg(AddrWindow, 32'd127);
    for (i = 0; i < 8; i++) send_sample(i[0] ? 24'hFF_FFFF : 24'h1, 1'b0);
    write_reg(AddrMult, 32'd0);
    send_sample(24'h00_0005, 1'b0);
    send_sample(24'hAB_CDEF, 1'b0);

    // Random phases, each with its own settings and idling pattern.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(AddrWindow, 32'd20); write_reg(AddrMult, 32'd512);
        end
        1: begin
          write_reg(AddrWindow, 32'd1); write_reg(AddrMult, 32'd4095);
        end
        2: begin
          write_reg(AddrWindow, 32'd64); write_reg(AddrMult, 32'd0);
        end
        3: begin
          write_reg(AddrWindow, 32'd3); write_reg(AddrMult, 32'd256);
        end
        4: begin
          write_reg(AddrWindow, 32'd64); write_reg(AddrMult, 32'd4095);
        end
        default: begin
          write_reg(AddrWindow, $urandom_range(127));
          write_reg(AddrMult, $urandom_range(4095));
        end
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (i = 0; i < 220; i++) begin
        // Long receiver hold-off while samples keep being offered.
        if (phase == 0 && i == 60) hold_len = 600;
        // The sender pauses until every band result has come back.
        if (phase == 3 && i == 100) begin
          sample_ch.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        send_random();
      end
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
hdl/bbc_pkg.sv
hdl/bbc_stream_if.sv
hdl/bbc_ram.sv
hdl/bollinger_band_calculator.sv
hdl/bbc_checker.sv
sim/bollinger_band_calculator_checker.sv
sim/bollinger_band_calculator_tb.sv
